### rtl/core/fd_stencil_row_builder_unit_defines.svh
// Assertion macros for the stencil row builder.
// Used by the port checker; no other dependencies.
`ifndef FD_STENCIL_ROW_BUILDER_UNIT_DEFINES_SVH
`define FD_STENCIL_ROW_BUILDER_UNIT_DEFINES_SVH
// implication checked on every clock, off in reset
`define FDS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
// next-cycle implication, off in reset
`define FDS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`endif

### rtl/core/fdsrb_pkg.sv
// Shared types and constants of the stencil row builder.
// No dependencies.
package fdsrb_pkg;
   localparam int unsigned WORD_W = 48;
   localparam int unsigned UWORD_W = 47;
   localparam int unsigned CSR_IDX_W = 2;
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_INTERIOR = 2'd0;
   localparam kind_type KIND_LEFT = 2'd1;
   localparam kind_type KIND_RIGHT = 2'd2;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_TIME_WEIGHT = 2'd0;
   localparam csr_idx_type CSR_HALF_WEIGHT = 2'd1;
   localparam csr_idx_type CSR_LEFT_FIXED = 2'd2;
   localparam csr_idx_type CSR_RIGHT_FIXED = 2'd3;
   localparam logic signed [WORD_W-1:0] QMAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] QMIN = {1'b1, {(WORD_W-1){1'b0}}};

   function automatic logic signed [WORD_W-1:0] sat49(input logic signed [WORD_W:0] x);
      if (x[WORD_W] != x[WORD_W-1]) begin
         sat49 = x[WORD_W] ? QMIN : QMAX;
      end else begin
         sat49 = x[WORD_W-1:0];
      end
   endfunction

   function automatic logic signed [WORD_W-1:0] qadd(input logic signed [WORD_W-1:0] a,
                                                     input logic signed [WORD_W-1:0] b);
      qadd = sat49({a[WORD_W-1], a} + {b[WORD_W-1], b});
   endfunction

   function automatic logic signed [WORD_W-1:0] qsub(input logic signed [WORD_W-1:0] a,
                                                     input logic signed [WORD_W-1:0] b);
      qsub = sat49({a[WORD_W-1], a} - {b[WORD_W-1], b});
   endfunction

   function automatic logic signed [WORD_W-1:0] qneg(input logic signed [WORD_W-1:0] a);
      qneg = sat49(-{a[WORD_W-1], a});
   endfunction

   function automatic logic signed [WORD_W-1:0] half(input logic signed [WORD_W-1:0] a);
      logic signed [WORD_W-1:0] t;
      t = a + {{(WORD_W-1){1'b0}}, a[WORD_W-1]};
      half = t >>> 1;
   endfunction
endpackage

### rtl/core/fdsrb_qmul.sv
// Saturating Q multiplier: magnitudes, split products, then sum and scale.
// Depends on fdsrb_pkg.
module fdsrb_qmul #(
   parameter int FRAC_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic signed [fdsrb_pkg::WORD_W-1:0]   a,
   input  logic signed [fdsrb_pkg::WORD_W-1:0]   b,
   output logic signed [fdsrb_pkg::WORD_W-1:0]   p
);
   localparam int W = fdsrb_pkg::WORD_W;
   localparam int H = W / 2;
   localparam int PW = 2 * W;
   logic [W-1:0] ma, mb;
   logic [W-1:0] ll_ff, lh_ff, hl_ff, hh_ff;
   logic neg_ff;
   logic [PW-1:0] full;
   logic [PW-1:0] q;
   logic ovf;

   assign ma = a[W-1] ? W'(-a) : W'(a);
   assign mb = b[W-1] ? W'(-b) : W'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff  <= ma[H-1:0] * mb[H-1:0];
         lh_ff  <= ma[H-1:0] * mb[W-1:H];
         hl_ff  <= ma[W-1:H] * mb[H-1:0];
         hh_ff  <= ma[W-1:H] * mb[W-1:H];
         neg_ff <= a[W-1] ^ b[W-1];
      end
   end

   assign full = PW'(ll_ff) + (PW'(lh_ff) << H) + (PW'(hl_ff) << H) + (PW'(hh_ff) << W);
   assign q = full >> FRAC_BITS;
   assign ovf = |q[PW-1:W-1];

   always_comb begin
      if (neg_ff) begin
         if (ovf && !(q == PW'({1'b1, {(W-1){1'b0}}}))) p = fdsrb_pkg::QMIN;
         else p = W'(-q);
      end else begin
         if (ovf) p = fdsrb_pkg::QMAX;
         else p = q[W-1:0];
      end
   end
endmodule

### rtl/core/fd_stencil_row_builder_unit.sv
// Top level of the stencil row builder: three-way weighted pipeline and row assembly.
// Depends on fdsrb_pkg and fdsrb_qmul.
//
// Usage: pulse start with the node fields on req_*; busy is always low, so a
// transaction is taken every cycle. Each transaction yields one row on rsp_*,
// marked by rsp_valid for one cycle. Throughput is one node per clock; the
// pipeline is an input stage, two chained multiply levels each followed by a
// register stage, and an output stage.
// The three stencil variants (central, forward, backward) run side by side.
// Registers are written on csr_we at any time; write only when idle so rows
// in flight see a single setting. Synchronous reset clears the valid bits
// and restores time_weight to 1.0, theta to one and both boundary rows to
// plain rows. The receiver cannot stall: rsp_valid is never held back and
// no result waits.
module fd_stencil_row_builder_unit #(
   parameter int FRAC_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_node_kind,
   input  logic signed [47:0]                    req_second_coef,
   input  logic signed [47:0]                    req_first_coef,
   input  logic signed [47:0]                    req_zero_coef,
   input  logic [46:0]                           req_inv_spacing_left,
   input  logic [46:0]                           req_inv_spacing_right,
   input  logic [46:0]                           req_inv_cell_width,
   input  logic                                  csr_we,
   input  logic [1:0]                            csr_index,
   input  logic [46:0]                           csr_wdata,
   output logic                                  rsp_valid,
   output logic signed [47:0]                    rsp_alpha,
   output logic signed [47:0]                    rsp_beta,
   output logic signed [47:0]                    rsp_diag_lower,
   output logic signed [47:0]                    rsp_diag_main,
   output logic signed [47:0]                    rsp_diag_upper
);
   localparam int W = fdsrb_pkg::WORD_W;
   localparam logic signed [W-1:0] ONE = W'(64'd1 << FRAC_BITS);
   typedef logic signed [W-1:0] q_type;

   q_type tw_ff;
   logic hw_ff, lf_ff, rf_ff;
   logic [5:0] v_ff;
   logic en;

   assign busy = 1'b0;
   assign en = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tw_ff <= ONE;
         hw_ff <= 1'b0;
         lf_ff <= 1'b0;
         rf_ff <= 1'b0;
         v_ff  <= '0;
      end else begin
         v_ff <= {v_ff[4:0], start};
         if (csr_we) begin
            case (csr_index)
               fdsrb_pkg::CSR_TIME_WEIGHT: tw_ff <= q_type'({1'b0, csr_wdata});
               fdsrb_pkg::CSR_HALF_WEIGHT: hw_ff <= csr_wdata[0];
               fdsrb_pkg::CSR_LEFT_FIXED:  lf_ff <= csr_wdata[0];
               fdsrb_pkg::CSR_RIGHT_FIXED: rf_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // stage 0: register inputs
   fdsrb_pkg::kind_type k0_ff;
   q_type c2_0, c1_0, c0_0, dl_0, dr_0, ia_0;
   always_ff @(posedge clock) begin
      k0_ff <= req_node_kind;
      c2_0 <= req_second_coef;
      c1_0 <= req_first_coef;
      c0_0 <= req_zero_coef;
      dl_0 <= q_type'({1'b0, req_inv_spacing_left});
      dr_0 <= q_type'({1'b0, req_inv_spacing_right});
      ia_0 <= q_type'({1'b0, req_inv_cell_width});
   end

   // first multiply level
   q_type m_c2dl, m_c2dr, m_c2ia, m_lb, m_rb;
   fdsrb_qmul #(.FRAC_BITS(FRAC_BITS)) u_m0 (.clock, .en, .a(c2_0), .b(dl_0), .p(m_c2dl));
   fdsrb_qmul #(.FRAC_BITS(FRAC_BITS)) u_m1 (.clock, .en, .a(c2_0), .b(dr_0), .p(m_c2dr));
   fdsrb_qmul #(.FRAC_BITS(FRAC_BITS)) u_m2 (.clock, .en, .a(c2_0), .b(ia_0), .p(m_c2ia));
   fdsrb_qmul #(.FRAC_BITS(FRAC_BITS)) u_m3 (.clock, .en, .a(c1_0), .b(dr_0), .p(m_lb));
   fdsrb_qmul #(.FRAC_BITS(FRAC_BITS)) u_m4 (.clock, .en, .a(fdsrb_pkg::qneg(c1_0)),
                                             .b(dl_0), .p(m_rb));

   fdsrb_pkg::kind_type k1_ff, k2_ff, k3_ff, k4_ff;
   q_type c1_1, c0_1, c0_2, c0_3, c0_4, dl_1, dl_2, dr_1, dr_2, ia_1, ia_2;
   always_ff @(posedge clock) begin
      k1_ff <= k0_ff; k2_ff <= k1_ff; k3_ff <= k2_ff; k4_ff <= k3_ff;
      c1_1 <= c1_0;
      c0_1 <= c0_0; c0_2 <= c0_1; c0_3 <= c0_2; c0_4 <= c0_3;
      dl_1 <= dl_0; dl_2 <= dl_1;
      dr_1 <= dr_0; dr_2 <= dr_1;
      ia_1 <= ia_0; ia_2 <= ia_1;
   end

   // stage 2: operand sums for second multiply level
   q_type ca_a, ca_b, fw_b, bw_a, c2dl_2, c2dr_2, lb_2, rb_2;
   always_ff @(posedge clock) begin
      ca_a   <= fdsrb_pkg::qsub(m_c2dl, c1_1 / 2);
      ca_b   <= fdsrb_pkg::qadd(m_c2dr, c1_1 / 2);
      fw_b   <= fdsrb_pkg::qadd(m_c2ia, c1_1);
      bw_a   <= fdsrb_pkg::qsub(m_c2ia, c1_1);
      c2dl_2 <= m_c2dl;
      c2dr_2 <= m_c2dr;
      lb_2   <= m_lb;
      rb_2   <= m_rb;
   end

   q_type p_ca, p_cb, p_fa, p_fb, p_ba, p_bb;
   fdsrb_qmul #(.FRAC_BITS(FRAC_BITS)) u_n0 (.clock, .en, .a(ca_a), .b(ia_2), .p(p_ca));
   fdsrb_qmul #(.FRAC_BITS(FRAC_BITS)) u_n1 (.clock, .en, .a(ca_b), .b(ia_2), .p(p_cb));
   fdsrb_qmul #(.FRAC_BITS(FRAC_BITS)) u_n2 (.clock, .en, .a(c2dl_2), .b(ia_2), .p(p_fa));
   fdsrb_qmul #(.FRAC_BITS(FRAC_BITS)) u_n3 (.clock, .en, .a(fw_b), .b(dr_2), .p(p_fb));
   fdsrb_qmul #(.FRAC_BITS(FRAC_BITS)) u_n4 (.clock, .en, .a(bw_a), .b(dl_2), .p(p_ba));
   fdsrb_qmul #(.FRAC_BITS(FRAC_BITS)) u_n5 (.clock, .en, .a(c2dr_2), .b(ia_2), .p(p_bb));

   // stage 4: hold weight products beside the boundary weights
   q_type lb_3, lb_4, rb_3, rb_4, ca_4, cb_4, fa_4, fb_4, ba_4, bb_4;
   always_ff @(posedge clock) begin
      lb_3 <= lb_2; lb_4 <= lb_3;
      rb_3 <= rb_2; rb_4 <= rb_3;
      ca_4 <= p_ca; cb_4 <= p_cb;
      fa_4 <= p_fa; fb_4 <= p_fb;
      ba_4 <= p_ba; bb_4 <= p_bb;
   end

   // stage 4 comb: choose weights and assemble row
   q_type a_sel, b_sel, a_mid, b_mid, s_ab, lo_n, mn_n, up_n;
   always_comb begin
      a_mid = ca_4;
      b_mid = cb_4;
      if (ca_4[W-1]) begin
         a_mid = fa_4;
         b_mid = fb_4;
      end
      if (b_mid[W-1]) begin
         a_mid = ba_4;
         b_mid = bb_4;
      end
      case (k4_ff)
         fdsrb_pkg::KIND_LEFT: begin
            a_sel = '0;
            b_sel = lb_4;
         end
         fdsrb_pkg::KIND_RIGHT: begin
            a_sel = rb_4;
            b_sel = '0;
         end
         default: begin
            a_sel = a_mid;
            b_sel = b_mid;
         end
      endcase
      s_ab = fdsrb_pkg::qadd(fdsrb_pkg::qadd(a_sel, b_sel), c0_4);
      lo_n = fdsrb_pkg::qneg(hw_ff ? fdsrb_pkg::half(a_sel) : a_sel);
      up_n = fdsrb_pkg::qneg(hw_ff ? fdsrb_pkg::half(b_sel) : b_sel);
      mn_n = fdsrb_pkg::qadd(tw_ff, hw_ff ? fdsrb_pkg::half(s_ab) : s_ab);
      if ((k4_ff == fdsrb_pkg::KIND_LEFT && lf_ff) ||
          (k4_ff == fdsrb_pkg::KIND_RIGHT && rf_ff)) begin
         lo_n = '0;
         up_n = '0;
         mn_n = ONE;
      end
   end

   always_ff @(posedge clock) begin
      rsp_alpha      <= a_sel;
      rsp_beta       <= b_sel;
      rsp_diag_lower <= lo_n;
      rsp_diag_main  <= mn_n;
      rsp_diag_upper <= up_n;
   end

   assign rsp_valid = v_ff[5];
endmodule

### rtl/core/fdsrb_checker.sv
// Port checker for the stencil row builder, bound to the top level.
// Depends on fd_stencil_row_builder_unit_defines.svh.
`include "fd_stencil_row_builder_unit_defines.svh"
module fdsrb_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   `FDS_ASSERT_IMP(a_never_busy, clock, reset, 1'b1, !busy)
   `FDS_ASSERT_IMP(a_latency, clock, reset, $past(start, 6) && !$past(reset, 6) && !$past(reset, 5) && !$past(reset, 4) && !$past(reset, 3) && !$past(reset, 2) && !$past(reset, 1), rsp_valid)
   `FDS_ASSERT_IMP(a_no_spurious, clock, reset, rsp_valid && !$past(reset, 6) && !$past(reset, 5) && !$past(reset, 4) && !$past(reset, 3) && !$past(reset, 2) && !$past(reset, 1), $past(start, 6))
endmodule

bind fd_stencil_row_builder_unit fdsrb_checker u_fdsrb_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid)
);
